// ===== hw/rtl/udw_pkg.sv =====
package udw_pkg;

	// scan mode codes
	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_ESC  = 3'd1;
	localparam logic [2:0] MODE_CSI  = 3'd2;
	localparam logic [2:0] MODE_UTF0 = 3'd3;
	localparam logic [2:0] MODE_UTF1 = 3'd4;
	localparam logic [2:0] MODE_UTF2 = 3'd5;

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] CSI_BYTE = 8'h5B;

	// decoded code point, wide enough for any unchecked 4-byte form
	localparam int CP_BITS = 23;

	localparam int ZERO_N = 5;
	localparam int WIDE_N = 45;

	localparam logic [CP_BITS-1:0] ZERO_LO [ZERO_N] = '{
		23'h0300, 23'h200B, 23'h20D0, 23'hFE00, 23'hFE20
	};
	localparam logic [CP_BITS-1:0] ZERO_HI [ZERO_N] = '{
		23'h036F, 23'h200F, 23'h20FF, 23'hFE0F, 23'hFE2F
	};

	localparam logic [CP_BITS-1:0] WIDE_LO [WIDE_N] = '{
		23'h1100,  23'h231A,  23'h23E9,  23'h23F0,  23'h23F3,  23'h25FD,  23'h2614,
		23'h2648,  23'h267F,  23'h2693,  23'h26A1,  23'h26AA,  23'h26BD,  23'h26C4,
		23'h26CE,  23'h26D4,  23'h26EA,  23'h26F2,  23'h26F5,  23'h26FA,  23'h26FD,
		23'h2705,  23'h270A,  23'h2728,  23'h274C,  23'h274E,  23'h2753,  23'h2757,
		23'h2795,  23'h27B0,  23'h27BF,  23'h2B1B,  23'h2B50,  23'h2B55,  23'h2E80,
		23'hAC00,  23'hF900,  23'hFE30,  23'hFF00,  23'hFFE0,  23'h1F300, 23'h1F680,
		23'h1F900, 23'h1FA70, 23'h20000
	};
	localparam logic [CP_BITS-1:0] WIDE_HI [WIDE_N] = '{
		23'h115F,  23'h231B,  23'h23EC,  23'h23F0,  23'h23F3,  23'h25FE,  23'h2615,
		23'h2653,  23'h267F,  23'h2693,  23'h26A1,  23'h26AB,  23'h26BE,  23'h26C5,
		23'h26CE,  23'h26D4,  23'h26EA,  23'h26F3,  23'h26F5,  23'h26FA,  23'h26FD,
		23'h2705,  23'h270B,  23'h2728,  23'h274C,  23'h274E,  23'h2755,  23'h2757,
		23'h2797,  23'h27B0,  23'h27BF,  23'h2B1C,  23'h2B50,  23'h2B55,  23'hA4CF,
		23'hD7A3,  23'hFAFF,  23'hFE6F,  23'hFF60,  23'hFFE6,  23'h1F64F, 23'h1F6FF,
		23'h1F9FF, 23'h1FAFF, 23'h3FFFD
	};

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] need;
		logic [7:0] lead;
		logic [7:0] held0;
		logic [7:0] held1;
	} udw_ctl_t;

endpackage

// ===== hw/rtl/udw_cols.sv =====
module udw_cols (
	input  logic [udw_pkg::CP_BITS-1:0] cp,
	output logic [1:0]                  cols
);

	logic [udw_pkg::ZERO_N-1:0] zero_hit;
	logic [udw_pkg::WIDE_N-1:0] wide_hit;
	logic                       ctrl;

	// parallel range comparators
	always_comb begin
		for (int i = 0; i < udw_pkg::ZERO_N; i++) begin
			zero_hit[i] = (cp >= udw_pkg::ZERO_LO[i]) && (cp <= udw_pkg::ZERO_HI[i]);
		end
		for (int i = 0; i < udw_pkg::WIDE_N; i++) begin
			wide_hit[i] = (cp >= udw_pkg::WIDE_LO[i]) && (cp <= udw_pkg::WIDE_HI[i]);
		end
	end

	assign ctrl = (cp < udw_pkg::CP_BITS'(8'h20))
		|| ((cp >= udw_pkg::CP_BITS'(8'h7F)) && (cp < udw_pkg::CP_BITS'(8'hA0)));

	always_comb begin
		if (ctrl || (|zero_hit)) begin
			cols = 2'd0;
		end else if (|wide_hit) begin
			cols = 2'd2;
		end else begin
			cols = 2'd1;
		end
	end

endmodule

// ===== hw/rtl/udw_step.sv =====
module udw_step #(
	parameter int WIDTH_BITS = 16
) (
	input  logic [7:0]            byte_in,
	input  udw_pkg::udw_ctl_t     ctl_in,
	input  logic [WIDTH_BITS-1:0] total_in,
	input  logic [WIDTH_BITS-1:0] esc_in,
	output udw_pkg::udw_ctl_t     ctl_out,
	output logic [WIDTH_BITS-1:0] total_out,
	output logic [WIDTH_BITS-1:0] esc_out,
	output logic                  fin,
	output logic [15:0]           result
);

	localparam int RW = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;
	localparam logic [WIDTH_BITS-1:0] SAT_MAX = {WIDTH_BITS{1'b1}};

	// width of a lone byte taken as a code point
	function automatic logic byte_cols(input logic [7:0] b);
		return !((b < 8'h20) || ((b >= 8'h7F) && (b < 8'hA0)));
	endfunction

	logic [1:0]                 held_n;
	logic [4:0]                 lead_m;
	logic [udw_pkg::CP_BITS-1:0] cp;
	logic [1:0]                 cp_cols;
	logic                       is_cont;
	logic [1:0]                 break_sum;
	logic                       do_plain;
	logic                       plain_add;
	logic [WIDTH_BITS-1:0]      extra;
	logic [WIDTH_BITS:0]        sum;
	logic [WIDTH_BITS-1:0]      sat;
	logic [RW-1:0]              sat_ext;

	assign held_n  = 2'(ctl_in.mode - udw_pkg::MODE_UTF0);
	assign is_cont = (byte_in[7:6] == 2'b10);

	always_comb begin
		unique case (ctl_in.need)
			2'd1:    lead_m = ctl_in.lead[4:0];
			2'd2:    lead_m = {1'b0, ctl_in.lead[3:0]};
			default: lead_m = {2'b0, ctl_in.lead[2:0]};
		endcase
	end

	always_comb begin
		unique case (held_n)
			2'd0:    cp = {12'b0, lead_m, byte_in[5:0]};
			2'd1:    cp = {6'b0, lead_m, ctl_in.held0[5:0], byte_in[5:0]};
			default: cp = {lead_m, ctl_in.held0[5:0], ctl_in.held1[5:0], byte_in[5:0]};
		endcase
	end

	udw_cols u_cols (
		.cp   (cp),
		.cols (cp_cols)
	);

	// lead and held bytes of a broken sequence count as single code points
	assign break_sum = {1'b0, byte_cols(ctl_in.lead)}
		+ {1'b0, (held_n != 2'd0) && byte_cols(ctl_in.held0)}
		+ {1'b0, (held_n == 2'd2) && byte_cols(ctl_in.held1)};

	always_comb begin
		ctl_out   = ctl_in;
		esc_out   = esc_in;
		extra     = '0;
		do_plain  = 1'b0;
		plain_add = 1'b0;
		fin       = 1'b0;

		unique case (ctl_in.mode)
			udw_pkg::MODE_ESC: begin
				if (byte_in == udw_pkg::CSI_BYTE) begin
					ctl_out.mode = udw_pkg::MODE_CSI;
					esc_out      = WIDTH_BITS'(1);
				end else begin
					do_plain = 1'b1;
				end
			end
			udw_pkg::MODE_CSI: begin
				if ((byte_in >= 8'h20) && (byte_in <= 8'h3F)) begin
					esc_out = (esc_in == SAT_MAX) ? esc_in : esc_in + 1'b1;
				end else if ((byte_in >= 8'h40) && (byte_in <= 8'h7E)) begin
					esc_out      = '0;
					ctl_out.mode = udw_pkg::MODE_IDLE;
				end else begin
					// unterminated sequence: '[' and parameters count one each
					extra    = esc_in;
					esc_out  = '0;
					do_plain = 1'b1;
				end
			end
			udw_pkg::MODE_UTF0, udw_pkg::MODE_UTF1, udw_pkg::MODE_UTF2: begin
				if (is_cont) begin
					if (({1'b0, held_n} + 3'd1) >= {1'b0, ctl_in.need}) begin
						extra        = WIDTH_BITS'(cp_cols);
						ctl_out.mode = udw_pkg::MODE_IDLE;
					end else begin
						if (held_n[0]) begin
							ctl_out.held1 = byte_in;
						end else begin
							ctl_out.held0 = byte_in;
						end
						ctl_out.mode = ctl_in.mode + 3'd1;
					end
				end else begin
					extra    = WIDTH_BITS'(break_sum);
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			ctl_out.mode = udw_pkg::MODE_IDLE;
			if (byte_in == 8'h00) begin
				fin = 1'b1;
			end else if (byte_in == udw_pkg::ESC_BYTE) begin
				ctl_out.mode = udw_pkg::MODE_ESC;
			end else if ((byte_in & 8'hE0) == 8'hC0) begin
				ctl_out.lead = byte_in;
				ctl_out.need = 2'd1;
				ctl_out.mode = udw_pkg::MODE_UTF0;
			end else if ((byte_in & 8'hF0) == 8'hE0) begin
				ctl_out.lead = byte_in;
				ctl_out.need = 2'd2;
				ctl_out.mode = udw_pkg::MODE_UTF0;
			end else if ((byte_in & 8'hF8) == 8'hF0) begin
				ctl_out.lead = byte_in;
				ctl_out.need = 2'd3;
				ctl_out.mode = udw_pkg::MODE_UTF0;
			end else begin
				plain_add = byte_cols(byte_in);
			end
		end

		if (fin) begin
			ctl_out = '0;
			esc_out = '0;
		end
	end

	// all increments are non-negative, so one clamp covers the whole step
	assign sum       = {1'b0, total_in} + {1'b0, extra} + (WIDTH_BITS+1)'(plain_add);
	assign sat       = sum[WIDTH_BITS] ? SAT_MAX : sum[WIDTH_BITS-1:0];
	assign total_out = fin ? '0 : sat;
	assign sat_ext   = RW'(sat);
	assign result    = (sat_ext > RW'(16'hFFFF)) ? 16'hFFFF : sat_ext[15:0];

endmodule

// ===== hw/rtl/utf8_display_width.sv =====
// a byte in the input register is decoded into the scanner state; a string's width shows
// on column_width through the result register once its zero byte is processed
// throughput: one byte per cycle, limited only by the single decode stage and the result
// register; a zero byte waits in the input register while an earlier width is not taken
// reset (arst_n low, asynchronous): both registers empty, scanner idle, totals cleared
module utf8_display_width #(
	parameter int WIDTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] column_width
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	udw_pkg::udw_ctl_t     ctl_q;
	logic [WIDTH_BITS-1:0] total_q;
	logic [WIDTH_BITS-1:0] esc_q;
	logic                  out_valid_q;
	logic [15:0]           column_width_q;

	udw_pkg::udw_ctl_t     ctl_d;
	logic [WIDTH_BITS-1:0] total_d;
	logic [WIDTH_BITS-1:0] esc_d;
	logic                  fin;
	logic [15:0]           result;
	logic                  out_free;
	logic                  proc;

	udw_step #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_step (
		.byte_in   (byte_s1),
		.ctl_in    (ctl_q),
		.total_in  (total_q),
		.esc_in    (esc_q),
		.ctl_out   (ctl_d),
		.total_out (total_d),
		.esc_out   (esc_d),
		.fin       (fin),
		.result    (result)
	);

	assign out_free = !out_valid_q || out_ready;
	// only an item that ends a string needs room in the result register
	assign proc     = valid_s1 && (!fin || out_free);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				byte_s1 <= text_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '0;
			total_q <= '0;
			esc_q   <= '0;
		end else if (proc) begin
			ctl_q   <= ctl_d;
			total_q <= total_d;
			esc_q   <= esc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			column_width_q <= '0;
		end else if (proc && fin) begin
			out_valid_q    <= 1'b1;
			column_width_q <= result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign column_width = column_width_q;

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && fin) |=> (ctl_q.mode == udw_pkg::MODE_IDLE && total_q == '0 && esc_q == '0))
		else $error("scanner state not cleared after a string ended");

	a_esc_only_in_csi: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.mode != udw_pkg::MODE_CSI) |-> (esc_q == '0))
		else $error("escape count held outside a control sequence");

	a_need_set: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.mode == udw_pkg::MODE_UTF0 || ctl_q.mode == udw_pkg::MODE_UTF1
			|| ctl_q.mode == udw_pkg::MODE_UTF2) |-> (ctl_q.need != 2'd0))
		else $error("multi-byte sequence open with no length");

	a_held_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		((ctl_q.mode == udw_pkg::MODE_UTF1) |-> (ctl_q.need >= 2'd2))
		and ((ctl_q.mode == udw_pkg::MODE_UTF2) |-> (ctl_q.need == 2'd3)))
		else $error("more continuation bytes held than the lead calls for");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !fin) |=> (total_q >= $past(total_q)))
		else $error("running width went down within a string");

endmodule
